[rtl/core/lr_pkg.sv]
// Package for the line rasterizer: widths, command codes and the queue entry type.
// Used by every module of the line rasterizer; depends on nothing.
package lr_pkg;

	// Coordinate and field widths
	localparam int COORD_BITS   = 11;
	localparam int DELTA_BITS   = COORD_BITS + 1;
	localparam int ERR_BITS     = COORD_BITS + 3;
	localparam int E2_BITS      = ERR_BITS + 1;
	localparam int STRIDE_BITS  = 13;
	localparam int ADDR_BITS    = 24;
	localparam int COLOR_BITS   = 8;
	localparam int PROD_BITS    = COORD_BITS + STRIDE_BITS;
	localparam int MULT_BITS    = (PROD_BITS > ADDR_BITS) ? PROD_BITS : ADDR_BITS;

	localparam logic [STRIDE_BITS-1:0] STRIDE_RESET = STRIDE_BITS'(640);

	// Command queue sizing
	localparam int QUEUE_DEPTH    = 4;
	localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);

	// Command codes
	typedef enum logic {
		CMD_START = 1'b0,
		CMD_STEP  = 1'b1
	} cmd_t;

	// Classified command as it travels from the front to the back
	typedef struct packed {
		cmd_t                          cmd;
		logic [COORD_BITS-1:0]         x0;
		logic [COORD_BITS-1:0]         y0;
		logic [COORD_BITS-1:0]         x1;
		logic [COORD_BITS-1:0]         y1;
		logic signed [DELTA_BITS-1:0]  dx;
		logic signed [DELTA_BITS-1:0]  ndy;
		logic                          step_x_neg;
		logic                          step_y_neg;
		logic signed [ERR_BITS-1:0]    err0;
		logic [COLOR_BITS-1:0]         color;
	} cmd_entry_t;

endpackage

[rtl/core/lr_front.sv]
// Front end of the line rasterizer: takes requests and classifies them.
// Computes deltas, step directions and the initial error for start commands; uses lr_pkg.
module lr_front import lr_pkg::*; (
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic                  command,
	input  logic [COORD_BITS-1:0] x_start,
	input  logic [COORD_BITS-1:0] y_start,
	input  logic [COORD_BITS-1:0] x_end,
	input  logic [COORD_BITS-1:0] y_end,
	input  logic [COLOR_BITS-1:0] line_color,
	input  logic                  queue_full,
	output logic                  push,
	output cmd_entry_t            entry
);

	logic [COORD_BITS-1:0] abs_dx;
	logic [COORD_BITS-1:0] abs_dy;
	logic signed [DELTA_BITS-1:0] dx;
	logic signed [DELTA_BITS-1:0] ndy;

	// Stall only on a full queue
	assign in_stall = queue_full;
	assign push     = in_valid && !queue_full;

	// Absolute deltas and signs
	assign abs_dx = (x_end >= x_start) ? (x_end - x_start) : (x_start - x_end);
	assign abs_dy = (y_end >= y_start) ? (y_end - y_start) : (y_start - y_end);
	assign dx     = DELTA_BITS'(abs_dx);
	assign ndy    = -DELTA_BITS'(abs_dy);

	// Build the queue entry
	always_comb begin
		entry.cmd        = cmd_t'(command);
		entry.x0         = x_start;
		entry.y0         = y_start;
		entry.x1         = x_end;
		entry.y1         = y_end;
		entry.dx         = dx;
		entry.ndy        = ndy;
		entry.step_x_neg = !(x_start < x_end);
		entry.step_y_neg = !(y_start < y_end);
		entry.err0       = ERR_BITS'(dx) + ERR_BITS'(ndy);
		entry.color      = line_color;
	end

endmodule

[rtl/core/lr_queue.sv]
// Short command queue between the front and the back of the line rasterizer.
// Register-based FIFO of classified commands; uses lr_pkg.
module lr_queue import lr_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  cmd_entry_t push_entry,
	input  logic       pop,
	output cmd_entry_t head,
	output logic       full,
	output logic       empty
);

	cmd_entry_t                mem_q [QUEUE_DEPTH];
	logic [QUEUE_PTR_BITS-1:0] wr_ptr_q;
	logic [QUEUE_PTR_BITS-1:0] rd_ptr_q;
	logic [QUEUE_PTR_BITS:0]   count_q;

	assign full  = (count_q == (QUEUE_PTR_BITS+1)'(QUEUE_DEPTH));
	assign empty = (count_q == '0);
	assign head  = mem_q[rd_ptr_q];

	// Advance pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !pop)
				count_q <= count_q + 1'b1;
			else if (pop && !push)
				count_q <= count_q - 1'b1;
		end
	end

	// Store entries
	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= push_entry;
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (!full || pop))
		else $error("command queue overflow");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty)
		else $error("command queue underflow");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= (QUEUE_PTR_BITS+1)'(QUEUE_DEPTH))
		else $error("command queue count out of range");

endmodule

[rtl/core/lr_back.sv]
// Back end of the line rasterizer: Bresenham stepping and pixel address stage.
// Pops classified commands from lr_queue, holds the stride register; uses lr_pkg.
module lr_back import lr_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_write,
	input  logic [STRIDE_BITS-1:0] cfg_data,
	input  cmd_entry_t             head,
	input  logic                   queue_empty,
	output logic                   pop,
	output logic                   out_valid,
	input  logic                   out_stall,
	output logic [COORD_BITS-1:0]  pixel_x,
	output logic [COORD_BITS-1:0]  pixel_y,
	output logic [ADDR_BITS-1:0]   pixel_address,
	output logic [COLOR_BITS-1:0]  pixel_color,
	output logic                   last_pixel
);

	// Line state
	logic                         busy_q;
	logic [COORD_BITS-1:0]        cur_x_q;
	logic [COORD_BITS-1:0]        cur_y_q;
	logic [COORD_BITS-1:0]        tgt_x_q;
	logic [COORD_BITS-1:0]        tgt_y_q;
	logic signed [DELTA_BITS-1:0] dx_q;
	logic signed [DELTA_BITS-1:0] ndy_q;
	logic                         sxn_q;
	logic                         syn_q;
	logic signed [ERR_BITS-1:0]   err_q;
	logic [COLOR_BITS-1:0]        color_q;
	logic [STRIDE_BITS-1:0]       stride_q;

	// Stage 1: stepped pixel
	logic                  valid_s1;
	logic [COORD_BITS-1:0] x_s1;
	logic [COORD_BITS-1:0] y_s1;
	logic [COLOR_BITS-1:0] color_s1;
	logic                  last_s1;

	// Stage 2: output register
	logic                  valid_s2;
	logic [COORD_BITS-1:0] x_s2;
	logic [COORD_BITS-1:0] y_s2;
	logic [ADDR_BITS-1:0]  addr_s2;
	logic [COLOR_BITS-1:0] color_s2;
	logic                  last_s2;

	logic                       s2_ready;
	logic                       s1_ready;
	logic                       do_start;
	logic                       do_step;
	logic                       at_target;
	logic signed [E2_BITS-1:0]  e2;
	logic                       move_x;
	logic                       move_y;
	logic signed [ERR_BITS-1:0] err_next;
	logic [MULT_BITS-1:0]       addr_wide;

	// Handshake between stages
	assign s2_ready = !valid_s2 || !out_stall;
	assign s1_ready = !valid_s1 || s2_ready;
	assign pop      = !queue_empty && s1_ready;
	assign do_start = pop && (head.cmd == CMD_START);
	assign do_step  = pop && (head.cmd == CMD_STEP) && busy_q;

	// Bresenham move decision
	assign at_target = (cur_x_q == tgt_x_q) && (cur_y_q == tgt_y_q);
	assign e2        = E2_BITS'(err_q) <<< 1;
	assign move_x    = (e2 >= E2_BITS'(ndy_q));
	assign move_y    = (e2 <= E2_BITS'(dx_q));
	assign err_next  = err_q + (move_x ? ERR_BITS'(ndy_q) : '0)
	                         + (move_y ? ERR_BITS'(dx_q) : '0);

	// Hold stride register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stride_q <= STRIDE_RESET;
		end else if (cfg_write) begin
			stride_q <= cfg_data;
		end
	end

	// Load a line on start, advance it on step
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			cur_x_q <= '0;
			cur_y_q <= '0;
			tgt_x_q <= '0;
			tgt_y_q <= '0;
			dx_q    <= '0;
			ndy_q   <= '0;
			sxn_q   <= 1'b0;
			syn_q   <= 1'b0;
			err_q   <= '0;
			color_q <= '0;
		end else if (do_start) begin
			busy_q  <= 1'b1;
			cur_x_q <= head.x0;
			cur_y_q <= head.y0;
			tgt_x_q <= head.x1;
			tgt_y_q <= head.y1;
			dx_q    <= head.dx;
			ndy_q   <= head.ndy;
			sxn_q   <= head.step_x_neg;
			syn_q   <= head.step_y_neg;
			err_q   <= head.err0;
			color_q <= head.color;
		end else if (do_step) begin
			if (at_target) begin
				busy_q <= 1'b0;
			end else begin
				err_q <= err_next;
				if (move_x)
					cur_x_q <= sxn_q ? cur_x_q - 1'b1 : cur_x_q + 1'b1;
				if (move_y)
					cur_y_q <= syn_q ? cur_y_q - 1'b1 : cur_y_q + 1'b1;
			end
		end
	end

	// Stage 1 valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s1_ready) begin
			valid_s1 <= do_step;
		end
	end

	// Stage 1 payload
	always_ff @(posedge clk) begin
		if (do_step) begin
			x_s1     <= cur_x_q;
			y_s1     <= cur_y_q;
			color_s1 <= color_q;
			last_s1  <= at_target;
		end
	end

	// Row times stride plus column, wrapped to the address width
	assign addr_wide = MULT_BITS'(y_s1) * MULT_BITS'(stride_q) + MULT_BITS'(x_s1);

	// Stage 2 valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s2_ready) begin
			valid_s2 <= valid_s1;
		end
	end

	// Stage 2 payload
	always_ff @(posedge clk) begin
		if (s2_ready && valid_s1) begin
			x_s2     <= x_s1;
			y_s2     <= y_s1;
			addr_s2  <= addr_wide[ADDR_BITS-1:0];
			color_s2 <= color_s1;
			last_s2  <= last_s1;
		end
	end

	assign out_valid     = valid_s2;
	assign pixel_x       = x_s2;
	assign pixel_y       = y_s2;
	assign pixel_address = addr_s2;
	assign pixel_color   = color_s2;
	assign last_pixel    = last_s2;

	a_last_goes_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(do_step && at_target) |=> !busy_q)
		else $error("engine still busy after the last pixel");

	a_step_moves: assert property (@(posedge clk) disable iff (!arst_n)
		(do_step && !at_target) |=>
		((cur_x_q != $past(cur_x_q)) || (cur_y_q != $past(cur_y_q))))
		else $error("step did not move the current pixel");

	a_s1_held: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !s2_ready) |=> (valid_s1 && $stable(x_s1) && $stable(y_s1)))
		else $error("stage 1 pixel lost while the output is stalled");

endmodule

[rtl/core/line_rasterizer_unit.sv]
// Top level of the line rasterizer: front end, command queue and back end.
// Instantiates lr_front, lr_queue and lr_back; uses lr_pkg.
//
// Bresenham line engine for all octants. A start request (command 0) loads two
// endpoints and a color and produces no pixel; each step request (command 1)
// produces one pixel with its column, row, byte address (row * frame_stride +
// column, modulo 2^24) and color, with last_pixel set on the far endpoint, after
// which the engine is idle and further steps produce nothing until the next start.
// A start while a line is active abandons that line. Requests pass through a
// four-entry command queue into the stepping engine, which retires one request per
// clock, so pixels come out at one per clock while the output is not stalled; the
// error update and the current-point compare form the loop that sets this rate.
// A step leaving the queue is registered in stage 1 (the Bresenham step), then in
// stage 2 (after the address multiply). in_stall rises only when the queue is full.
// frame_stride resets to 640; the user must write it with cfg_write and cfg_data
// only while the engine is idle, which the block itself does not enforce.
module line_rasterizer_unit import lr_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_write,
	input  logic [STRIDE_BITS-1:0] cfg_data,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic                   command,
	input  logic [COORD_BITS-1:0]  x_start,
	input  logic [COORD_BITS-1:0]  y_start,
	input  logic [COORD_BITS-1:0]  x_end,
	input  logic [COORD_BITS-1:0]  y_end,
	input  logic [COLOR_BITS-1:0]  line_color,
	output logic                   out_valid,
	input  logic                   out_stall,
	output logic [COORD_BITS-1:0]  pixel_x,
	output logic [COORD_BITS-1:0]  pixel_y,
	output logic [ADDR_BITS-1:0]   pixel_address,
	output logic [COLOR_BITS-1:0]  pixel_color,
	output logic                   last_pixel
);

	logic       push;
	logic       pop;
	logic       queue_full;
	logic       queue_empty;
	cmd_entry_t push_entry;
	cmd_entry_t head;

	// Classify incoming requests
	lr_front u_front (
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.command    (command),
		.x_start    (x_start),
		.y_start    (y_start),
		.x_end      (x_end),
		.y_end      (y_end),
		.line_color (line_color),
		.queue_full (queue_full),
		.push       (push),
		.entry      (push_entry)
	);

	// Buffer commands between front and back
	lr_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.head       (head),
		.full       (queue_full),
		.empty      (queue_empty)
	);

	// Step lines and form pixels
	lr_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_write     (cfg_write),
		.cfg_data      (cfg_data),
		.head          (head),
		.queue_empty   (queue_empty),
		.pop           (pop),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.pixel_x       (pixel_x),
		.pixel_y       (pixel_y),
		.pixel_address (pixel_address),
		.pixel_color   (pixel_color),
		.last_pixel    (last_pixel)
	);

endmodule

[dv/raster_sb_pkg.sv]
`timescale 1ns / 100ps
// Pixel scoreboard for the line rasterizer: a Bresenham predictor plus an in-order
// queue of expected pixels. Depends on lr_pkg for widths and command codes.
package raster_sb_pkg;
	import lr_pkg::*;

	typedef struct {
		logic [COORD_BITS-1:0] x;
		logic [COORD_BITS-1:0] y;
		logic [ADDR_BITS-1:0]  addr;
		logic [COLOR_BITS-1:0] color;
		logic                  last;
	} pixel_t;

	class pixel_scoreboard;
		logic [STRIDE_BITS-1:0]       stride;
		bit                           line_active;
		logic [COORD_BITS-1:0]        cur_x;
		logic [COORD_BITS-1:0]        cur_y;
		logic [COORD_BITS-1:0]        tgt_x;
		logic [COORD_BITS-1:0]        tgt_y;
		logic signed [DELTA_BITS-1:0] delta_x;
		logic signed [DELTA_BITS-1:0] neg_delta_y;
		bit                           x_down;
		bit                           y_down;
		logic signed [ERR_BITS-1:0]   err;
		logic [COLOR_BITS-1:0]        color;
		pixel_t                       expected_pixels[$];
		int                           error_count;

		function new();
			stride      = STRIDE_RESET;
			line_active = 1'b0;
			cur_x       = '0;
			cur_y       = '0;
			tgt_x       = '0;
			tgt_y       = '0;
			delta_x     = '0;
			neg_delta_y = '0;
			x_down      = 1'b0;
			y_down      = 1'b0;
			err         = '0;
			color       = '0;
			error_count = 0;
		endfunction

		// Advance the line state for one accepted request; return 1 unless it was ignored
		function bit note_request(cmd_t cmd, logic [COORD_BITS-1:0] x0, y0, x1, y1,
				logic [COLOR_BITS-1:0] c);
			int     span_x;
			int     span_y;
			int     twice_err;
			pixel_t px;

			// Load endpoints, deltas and initial error; abandon any active line
			if (cmd == CMD_START) begin
				span_x      = (x1 >= x0) ? int'(x1) - int'(x0) : int'(x0) - int'(x1);
				span_y      = (y1 >= y0) ? int'(y1) - int'(y0) : int'(y0) - int'(y1);
				cur_x       = x0;
				cur_y       = y0;
				tgt_x       = x1;
				tgt_y       = y1;
				delta_x     = DELTA_BITS'(span_x);
				neg_delta_y = DELTA_BITS'(-span_y);
				x_down      = !(x0 < x1);
				y_down      = !(y0 < y1);
				err         = ERR_BITS'(span_x - span_y);
				color       = c;
				line_active = 1'b1;
				return 1'b1;
			end

			// Drop steps while idle
			if (!line_active)
				return 1'b0;

			// Emit the current point
			px.x     = cur_x;
			px.y     = cur_y;
			px.addr  = ADDR_BITS'(int'(cur_y) * int'(stride) + int'(cur_x));
			px.color = color;
			px.last  = (cur_x == tgt_x) && (cur_y == tgt_y);
			expected_pixels.push_back(px);

			// Move one point along the line, or go idle at the far endpoint
			if (px.last) begin
				line_active = 1'b0;
			end else begin
				twice_err = 2 * int'(err);
				if (twice_err >= int'(neg_delta_y)) begin
					err   = ERR_BITS'(int'(err) + int'(neg_delta_y));
					cur_x = x_down ? cur_x - 1'b1 : cur_x + 1'b1;
				end
				if (twice_err <= int'(delta_x)) begin
					err   = ERR_BITS'(int'(err) + int'(delta_x));
					cur_y = y_down ? cur_y - 1'b1 : cur_y + 1'b1;
				end
			end
			return 1'b1;
		endfunction

		task report(string what);
			$display("[%0t] MISMATCH %s", $time, what);
			error_count++;
		endtask

		// Compare one accepted pixel with the oldest expected one
		task check_pixel(pixel_t got);
			pixel_t want;

			if (expected_pixels.size() == 0) begin
				report($sformatf("unexpected pixel x=%0d y=%0d", got.x, got.y));
				return;
			end
			want = expected_pixels.pop_front();
			if (got.x !== want.x)
				report($sformatf("pixel_x got %0d want %0d", got.x, want.x));
			if (got.y !== want.y)
				report($sformatf("pixel_y got %0d want %0d", got.y, want.y));
			if (got.addr !== want.addr)
				report($sformatf("pixel_address got %0d want %0d at (%0d,%0d)",
					got.addr, want.addr, want.x, want.y));
			if (got.color !== want.color)
				report($sformatf("pixel_color got %0d want %0d", got.color, want.color));
			if (got.last !== want.last)
				report($sformatf("last_pixel got %0b want %0b at (%0d,%0d)",
					got.last, want.last, want.x, want.y));
		endtask
	endclass

endpackage

[dv/tb_line_rasterizer_unit.sv]
`timescale 1ns / 100ps
// Testbench top for line_rasterizer_unit: directed and random start/step requests,
// random stalls on both sides, stride changes between phases.
// Depends on lr_pkg and raster_sb_pkg.
module tb_line_rasterizer_unit;
	import lr_pkg::*;
	import raster_sb_pkg::*;

	localparam int CYCLE_LIMIT   = 400000;
	localparam int SETTLE_CYCLES = 16;
	localparam int PHASE_ITEMS   = 200;
	localparam int COORD_MAX     = (1 << COORD_BITS) - 1;

	logic                   clk        = 1'b0;
	logic                   arst_n     = 1'b0;
	logic                   cfg_write  = 1'b0;
	logic [STRIDE_BITS-1:0] cfg_data   = '0;
	logic                   in_valid   = 1'b0;
	logic                   in_stall;
	logic                   command    = CMD_STEP;
	logic [COORD_BITS-1:0]  x_start    = '0;
	logic [COORD_BITS-1:0]  y_start    = '0;
	logic [COORD_BITS-1:0]  x_end      = '0;
	logic [COORD_BITS-1:0]  y_end      = '0;
	logic [COLOR_BITS-1:0]  line_color = '0;
	logic                   out_valid;
	logic                   out_stall  = 1'b0;
	logic [COORD_BITS-1:0]  pixel_x;
	logic [COORD_BITS-1:0]  pixel_y;
	logic [ADDR_BITS-1:0]   pixel_address;
	logic [COLOR_BITS-1:0]  pixel_color;
	logic                   last_pixel;

	pixel_scoreboard sb = new();
	int              work_items = 0;
	bit              steady     = 1'b0;
	bit              hold_off   = 1'b0;

	line_rasterizer_unit DUT (.*);

	initial begin
		forever #4 clk = ~clk;
	end

	// Abort a hung run
	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// Check accepted pixels, then pick the next stall
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_pixel('{pixel_x, pixel_y, pixel_address, pixel_color, last_pixel});
		out_stall <= hold_off || (!steady && $urandom_range(99) < 6);
	end

	// Hold off the output for a long stretch so the command queue fills
	initial begin
		wait (work_items >= 400);
		@(posedge clk);
		hold_off <= 1'b1;
		repeat (300) @(posedge clk);
		hold_off <= 1'b0;
	end

	// Offer one request and hold it until accepted
	task automatic send_request(cmd_t cmd, int x0, int y0, int x1, int y1, int c);
		while (!steady && $urandom_range(99) < 6) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid   <= 1'b1;
		command    <= cmd;
		x_start    <= COORD_BITS'(x0);
		y_start    <= COORD_BITS'(y0);
		x_end      <= COORD_BITS'(x1);
		y_end      <= COORD_BITS'(y1);
		line_color <= COLOR_BITS'(c);
		@(posedge clk);
		while (in_stall) @(posedge clk);
		if (sb.note_request(cmd, COORD_BITS'(x0), COORD_BITS'(y0), COORD_BITS'(x1),
				COORD_BITS'(y1), COLOR_BITS'(c)))
			work_items++;
	endtask

	// Step with junk in the unused fields
	task automatic send_step();
		send_request(CMD_STEP, $urandom_range(COORD_MAX), $urandom_range(COORD_MAX),
			$urandom_range(COORD_MAX), $urandom_range(COORD_MAX), $urandom_range(255));
	endtask

	// Drop valid, wait for every pixel, then let the pipeline drain
	task automatic settle_engine();
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.expected_pixels.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_stride(int value);
		cfg_write <= 1'b1;
		cfg_data  <= STRIDE_BITS'(value);
		@(posedge clk);
		cfg_write <= 1'b0;
		sb.stride = STRIDE_BITS'(value);
	endtask

	// Endpoint within span of a, kept on screen
	function automatic int nearby(int a, int span);
		int d;

		d = $urandom_range(span);
		if ($urandom_range(1))
			d = -d;
		if (a + d < 0 || a + d > COORD_MAX)
			d = -d;
		return a + d;
	endfunction

	// One random sequence: mostly whole lines, some abandoned lines, some noise
	task automatic random_burst();
		int kind;
		int x0;
		int y0;
		int x1;
		int y1;
		int len;
		int span;

		kind = $urandom_range(99);
		x0   = $urandom_range(COORD_MAX);
		y0   = $urandom_range(COORD_MAX);
		if (kind < 70) begin
			span = ($urandom_range(99) < 4) ? 300 : 12;
			x1   = nearby(x0, span);
			y1   = nearby(y0, span);
			len  = (x1 > x0) ? x1 - x0 : x0 - x1;
			if (((y1 > y0) ? y1 - y0 : y0 - y1) > len)
				len = (y1 > y0) ? y1 - y0 : y0 - y1;
			len++;
			if ($urandom_range(99) < 20)
				len += $urandom_range(1, 3);
		end else if (kind < 85) begin
			x1  = $urandom_range(COORD_MAX);
			y1  = $urandom_range(COORD_MAX);
			len = $urandom_range(5);
		end else if (kind < 95) begin
			repeat ($urandom_range(1, 4))
				send_request(cmd_t'($urandom_range(1)), $urandom_range(COORD_MAX),
					$urandom_range(COORD_MAX), $urandom_range(COORD_MAX),
					$urandom_range(COORD_MAX), $urandom_range(255));
			return;
		end else begin
			x1  = x0;
			y1  = y0;
			len = $urandom_range(1, 2);
		end
		send_request(CMD_START, x0, y0, x1, y1, $urandom_range(255));
		repeat (len) send_step();
	endtask

	initial begin
		int stride_plan[6];
		int target;

		stride_plan = '{0, 8191, 1, 4096, 0, 2047};
		stride_plan[4] = $urandom_range(8191);

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Step while idle after reset
		send_request(CMD_STEP, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, 255);
		// Single-point lines at both corners, with a step while idle after the first
		send_request(CMD_START, 0, 0, 0, 0, 0);
		send_step();
		send_step();
		send_request(CMD_START, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, 255);
		send_step();
		// Full-screen diagonals, each abandoned by the next start
		send_request(CMD_START, 0, 0, COORD_MAX, COORD_MAX, 8'hA5);
		repeat (3) send_step();
		send_request(CMD_START, COORD_MAX, 0, 0, COORD_MAX, 8'h5A);
		repeat (3) send_step();
		send_request(CMD_START, COORD_MAX, COORD_MAX, 0, 0, 8'h3C);
		repeat (2) send_step();
		// Short horizontal and vertical lines run to the end
		send_request(CMD_START, 2, 7, 0, 7, 8'h81);
		repeat (3) send_step();
		send_request(CMD_START, 3, 3, 3, 5, 8'h7E);
		repeat (3) send_step();

		// Random phases, one stride setting each
		foreach (stride_plan[p]) begin
			settle_engine();
			write_stride(stride_plan[p]);
			target = work_items + PHASE_ITEMS;
			while (work_items < target) begin
				steady <= (work_items >= 700 && work_items < 900);
				random_burst();
			end
		end
		steady <= 1'b0;
		settle_engine();

		if (sb.error_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
